FILE: rtl/core/b64c_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 codec package
// Shared payload types, the request passed from front to back, and the
// alphabet lookups used by both halves of the codec.
// ----------------------------------------------------------------------------
package b64c_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_item;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_error;
  } out_item_t;

  // One request from the front: a finished group and how to emit it.
  typedef struct packed {
    logic [23:0] group;
    logic [1:0]  cnt_m1;    // number of results minus one
    logic [1:0]  chr_last;  // encode: last sextet index that is a real character
    logic        enc;
    logic        err;
    logic        last;
  } job_t;

  typedef struct packed {
    logic       bad;
    logic       pad;
    logic [5:0] val;
  } sextet_t;

  function automatic logic [7:0] char_of(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t s;
    s = '{bad: 1'b0, pad: 1'b0, val: 6'd0};
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.val = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      s.val = 6'd62;
    end else if (c == 8'h2F) begin
      s.val = 6'd63;
    end else if (c == PAD_CHAR) begin
      s.pad = 1'b1;
    end else begin
      s.bad = 1'b1;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/base64_stream_codec.sv
// A group's request is queued and its results leave through the registered output stage.
// Throughput: one item a cycle into the front end while the queue is not full; results
// leave one a cycle while out_ready is high, so encoding runs at four characters per
// three bytes and is bounded by the output stage.
// The two-entry request queue lets the front end keep accepting while results drain.
// Reset (synchronous, rst_n low) selects encoding and clears all group and queue state.
`default_nettype none
// ----------------------------------------------------------------------------
// Streaming base64 codec
// Standard alphabet encoder and decoder with a direction register, padding
// and error reporting.
// ----------------------------------------------------------------------------
module base64_stream_codec import b64c_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cfg_we,
  input  wire logic      cfg_wdata,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic push;
  logic pop;
  logic full;
  logic empty;
  job_t push_job;
  job_t head;

  assign in_ready = !full;

  b64c_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (in_valid && in_ready),
    .item      (in_data),
    .push      (push),
    .job       (push_job)
  );

  b64c_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  b64c_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: rtl/core/b64c_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 codec front end
// Accepts items, gathers groups, checks decode syntax and issues one request
// per finished group or error.
// ----------------------------------------------------------------------------
module b64c_front import b64c_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cfg_we,
  input  wire logic     cfg_wdata,
  input  wire logic     accept,
  input  wire in_item_t item,
  output logic          push,
  output job_t          job
);

  logic        dir_r,   dir_nxt;
  logic [23:0] group_r, group_nxt;
  logic [1:0]  pos_r,   pos_nxt;
  logic [1:0]  pad_r,   pad_nxt;
  logic        drop_r,  drop_nxt;

  logic [1:0]  epos;
  logic [2:0]  posinc;
  logic [1:0]  pad_inc;
  logic [23:0] g_or;
  logic        fail;
  sextet_t     sx;

  always_comb begin
    dir_nxt   = dir_r;
    group_nxt = group_r;
    pos_nxt   = pos_r;
    pad_nxt   = pad_r;
    drop_nxt  = drop_r;
    push      = 1'b0;
    job       = '{group: group_r, cnt_m1: 2'd0, chr_last: 2'd0,
                  enc: 1'b0, err: 1'b0, last: item.last_item};
    fail      = 1'b0;
    sx        = sextet_of(item.data_byte);
    epos      = (pos_r == 2'd3) ? 2'd2 : pos_r;
    posinc    = {1'b0, pos_r} + 3'd1;
    pad_inc   = pad_r + 2'd1;
    g_or      = group_r;

    if (cfg_we) begin
      dir_nxt   = cfg_wdata;
      group_nxt = '0;
      pos_nxt   = '0;
      pad_nxt   = '0;
      drop_nxt  = 1'b0;
    end else if (accept) begin
      if (drop_r) begin
        if (item.last_item) begin
          drop_nxt  = 1'b0;
          group_nxt = '0;
          pos_nxt   = '0;
          pad_nxt   = '0;
        end
      end else if (dir_r == DIR_ENCODE) begin
        unique case (epos)
          2'd0:    g_or[23:16] = group_r[23:16] | item.data_byte;
          2'd1:    g_or[15:8]  = group_r[15:8]  | item.data_byte;
          default: g_or[7:0]   = group_r[7:0]   | item.data_byte;
        endcase
        if (epos != 2'd2 && !item.last_item) begin
          group_nxt = g_or;
          pos_nxt   = epos + 2'd1;
        end else begin
          push         = 1'b1;
          job.group    = g_or;
          job.enc      = 1'b1;
          job.cnt_m1   = 2'd3;
          job.chr_last = epos + 2'd1;
          group_nxt    = '0;
          pos_nxt      = '0;
          pad_nxt      = '0;
        end
      end else begin
        unique case (pos_r)
          2'd0:    g_or[23:18] = group_r[23:18] | sx.val;
          2'd1:    g_or[17:12] = group_r[17:12] | sx.val;
          2'd2:    g_or[11:6]  = group_r[11:6]  | sx.val;
          default: g_or[5:0]   = group_r[5:0]   | sx.val;
        endcase
        if (sx.bad) begin
          fail = 1'b1;
        end else if (sx.pad && pos_r < 2'd2) begin
          fail = 1'b1;
        end else if (!sx.pad && pad_r != 2'd0) begin
          fail = 1'b1;
        end else begin
          if (sx.pad) begin
            g_or = group_r;
          end else begin
            pad_inc = pad_r;
          end
          if (posinc < 3'd4) begin
            if (item.last_item) begin
              fail = 1'b1;
            end else begin
              group_nxt = g_or;
              pos_nxt   = posinc[1:0];
              pad_nxt   = pad_inc;
            end
          end else if (pad_inc != 2'd0 && !item.last_item) begin
            fail = 1'b1;
          end else begin
            push       = 1'b1;
            job.group  = g_or;
            job.cnt_m1 = 2'd2 - pad_inc;
            group_nxt  = '0;
            pos_nxt    = '0;
            pad_nxt    = '0;
          end
        end
        if (fail) begin
          push      = 1'b1;
          job.err   = 1'b1;
          job.last  = 1'b1;
          group_nxt = '0;
          pos_nxt   = '0;
          pad_nxt   = '0;
          drop_nxt  = !item.last_item;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r   <= DIR_ENCODE;
      group_r <= '0;
      pos_r   <= '0;
      pad_r   <= '0;
      drop_r  <= 1'b0;
    end else begin
      dir_r   <= dir_nxt;
      group_r <= group_nxt;
      pos_r   <= pos_nxt;
      pad_r   <= pad_nxt;
      drop_r  <= drop_nxt;
    end
  end

  // An error request always carries exactly one result.
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    push && job.err |-> job.cnt_m1 == 2'd0 && job.last)
    else $error("error request with more than one result");

endmodule
`default_nettype wire

FILE: rtl/core/b64c_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 codec request queue
// Two-entry queue that decouples the front end from the result sequencer.
// ----------------------------------------------------------------------------
module b64c_fifo import b64c_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head,
  output logic      full,
  output logic      empty
);

  job_t       mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r,  cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r ^ push;
    rptr_nxt = rptr_r ^ pop;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("request pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("request popped from an empty queue");

endmodule
`default_nettype wire

FILE: rtl/core/b64c_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 codec result sequencer
// Takes requests from the queue and emits their results, one a cycle while the
// output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module b64c_back import b64c_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire job_t head,
  input  wire logic empty,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_data
);

  logic      vld_r, vld_nxt;
  logic [1:0] k_r,  k_nxt;
  out_item_t dat_r, dat_nxt;
  logic      load;
  logic [5:0] sx;
  logic [7:0] dbyte;

  assign out_valid = vld_r;
  assign out_data  = dat_r;

  always_comb begin
    unique case (k_r)
      2'd0:    sx = head.group[23:18];
      2'd1:    sx = head.group[17:12];
      2'd2:    sx = head.group[11:6];
      default: sx = head.group[5:0];
    endcase
    unique case (k_r)
      2'd0:    dbyte = head.group[23:16];
      2'd1:    dbyte = head.group[15:8];
      default: dbyte = head.group[7:0];
    endcase

    load    = !empty && (!vld_r || out_ready);
    pop     = load && (k_r == head.cnt_m1);
    vld_nxt = load ? 1'b1 : (vld_r && !out_ready);
    k_nxt   = k_r;
    dat_nxt = dat_r;
    if (load) begin
      k_nxt = pop ? 2'd0 : k_r + 2'd1;
      dat_nxt.out_last  = head.last && (k_r == head.cnt_m1);
      dat_nxt.out_error = head.err;
      priority if (head.err) begin
        dat_nxt.out_byte = 8'h00;
      end else if (head.enc) begin
        dat_nxt.out_byte = (k_r <= head.chr_last) ? char_of(sx) : PAD_CHAR;
      end else begin
        dat_nxt.out_byte = dbyte;
      end
    end
  end

  always_ff @(posedge clk) begin
    dat_r <= dat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      k_r   <= 2'd0;
    end else begin
      vld_r <= vld_nxt;
      k_r   <= k_nxt;
    end
  end

  // An error result is always the zero byte that ends its stream.
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && dat_r.out_error |-> dat_r.out_last && dat_r.out_byte == 8'h00)
    else $error("malformed error result");

endmodule
`default_nettype wire

FILE: dv/base64_stream_codec_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 stream codec testbench
// Directed and random byte and character streams in both directions. Every
// accepted item goes through a predictor of the codec, and each result is
// compared field by field with the oldest result still awaited.
// ----------------------------------------------------------------------------
module base64_stream_codec_tb import b64c_pkg::*;;

  localparam int IDLE_LIMIT  = 1000;
  localparam int DRAIN_WAIT  = 10;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 56;
  localparam int SEXTET_PAD  = 64;
  localparam int SEXTET_BAD  = -1;
  localparam int MAX_PRINTS  = 50;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      cfg_we    = 1'b0;
  logic      cfg_wdata = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Codec state as the predictor tracks it.
  logic        pred_dir   = DIR_ENCODE;
  logic [23:0] pred_group = '0;
  logic [1:0]  pred_pos   = '0;
  logic [1:0]  pred_pads  = '0;
  logic        pred_drop  = 1'b0;

  out_item_t awaited_results[$];
  string     b64_set     = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  int        fail_count  = 0;
  int        idle_cycles = 0;
  int        ready_stall = 0;
  int        items_sent  = 0;
  bit        jitter      = 1'b1;

  base64_stream_codec uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (!jitter) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] b64_char(input int v);
    return b64_set[v];
  endfunction

  function automatic int sextet_value(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (b64_set[i] == c) return i;
    end
    if (c == PAD_CHAR) return SEXTET_PAD;
    return SEXTET_BAD;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTS) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic push_result(input logic [7:0] b, input logic last, input logic err);
    out_item_t r;
    r.out_byte  = b;
    r.out_last  = last;
    r.out_error = err;
    awaited_results.push_back(r);
  endtask

  task automatic clear_pred_group();
    pred_group = '0;
    pred_pos   = '0;
    pred_pads  = '0;
  endtask

  task automatic decode_error(input logic last);
    clear_pred_group();
    pred_drop = !last;
    push_result(8'h00, 1'b1, 1'b1);
  endtask

  task automatic predict_codec(input in_item_t it);
    int pos;
    int v;
    int n;
    // After an error everything up to and including the next last item is swallowed.
    if (pred_drop) begin
      if (it.last_item) begin
        pred_drop = 1'b0;
        clear_pred_group();
      end
      return;
    end
    pos = pred_pos;
    if (pred_dir == DIR_ENCODE) begin
      pred_group = pred_group | (24'(it.data_byte) << (16 - 8 * pos));
      pos++;
      if (pos < 3 && !it.last_item) begin
        pred_pos = 2'(pos);
        return;
      end
      // A short final group emits pos+1 real characters and pads the rest.
      for (int i = 0; i < 4; i++) begin
        if (i <= pos) begin
          push_result(b64_char(int'((pred_group >> (18 - 6 * i)) & 24'h3F)),
                      it.last_item && i == 3, 1'b0);
        end else begin
          push_result(PAD_CHAR, it.last_item && i == 3, 1'b0);
        end
      end
      clear_pred_group();
      return;
    end
    v = sextet_value(it.data_byte);
    if (v == SEXTET_BAD) begin
      decode_error(it.last_item);
      return;
    end
    if (v == SEXTET_PAD) begin
      if (pos < 2) begin
        decode_error(it.last_item);
        return;
      end
      pred_pads = pred_pads + 2'd1;
    end else begin
      if (pred_pads != 2'd0) begin
        decode_error(it.last_item);
        return;
      end
      pred_group = pred_group | (24'(v) << (18 - 6 * pos));
    end
    pos++;
    if (pos < 4) begin
      if (it.last_item) begin
        decode_error(it.last_item);
        return;
      end
      pred_pos = 2'(pos);
      return;
    end
    if (pred_pads != 2'd0 && !it.last_item) begin
      decode_error(it.last_item);
      return;
    end
    n = 3 - int'(pred_pads);
    for (int i = 0; i < n; i++) begin
      push_result(8'(pred_group >> (16 - 8 * i)), it.last_item && i == n - 1, 1'b0);
    end
    clear_pred_group();
  endtask

  task automatic send_item(input logic [7:0] b, input logic last);
    int gap;
    in_item_t it;
    gap          = pick_gap();
    it.data_byte = b;
    it.last_item = last;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predict_codec(it);
    items_sent++;
  endtask

  task automatic send_text(input string s, input bit last_at_end);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], last_at_end && i == s.len() - 1);
    end
  endtask

  // The register may only change once every awaited result is out and the
  // pipeline has had time to settle.
  task automatic set_direction(input logic d);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
    pred_dir  = d;
    pred_drop = 1'b0;
    clear_pred_group();
  endtask

  task automatic test_encode_directed();
    set_direction(DIR_ENCODE);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'h7F, 1'b1);
    // Left open so that the next register write has a partial group to clear.
    send_item(8'h55, 1'b0);
    send_item(8'hAA, 1'b0);
  endtask

  task automatic test_decode_directed();
    set_direction(DIR_DECODE);
    send_text("TR==", 1'b1);
    send_text("*AB", 1'b1);
    send_text("=", 1'b1);
    send_text("A=", 1'b1);
    send_text("AB=C", 1'b1);
    send_text("TW", 1'b1);
    // A padded group that is not final leaves the codec discarding input.
    send_text("TQ==", 1'b0);
  endtask

  task automatic send_encode_stream();
    int  len;
    bit  open;
    len  = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 10) : $urandom_range(11, 30);
    open = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < len; i++) begin
      send_item(8'($urandom_range(0, 255)), i == len - 1 && !open);
    end
  endtask

  task automatic send_decode_stream();
    logic [7:0] chars[$];
    int         groups;
    int         pads;
    int         flaw;
    int         at;
    bit         open;
    groups = $urandom_range(1, 3);
    for (int i = 0; i < 4 * groups; i++) chars.push_back(b64_char($urandom_range(0, 63)));
    pads = $urandom_range(0, 2);
    for (int k = 0; k < pads; k++) chars[chars.size() - 1 - k] = PAD_CHAR;
    flaw = $urandom_range(0, 99);
    at   = $urandom_range(0, chars.size() - 1);
    open = 1'b0;
    if (flaw < 8) begin
      chars[at] = 8'($urandom_range(0, 255));
    end else if (flaw < 14) begin
      chars[at] = PAD_CHAR;
    end else if (flaw < 20) begin
      while (chars.size() > at + 1) void'(chars.pop_back());
    end else if (flaw < 24) begin
      chars.insert(at, b64_char($urandom_range(0, 63)));
    end else if (flaw < 28) begin
      open = 1'b1;
    end
    for (int i = 0; i < chars.size(); i++) begin
      send_item(chars[i], i == chars.size() - 1 && !open);
    end
  endtask

  task automatic send_noise();
    int len;
    len = $urandom_range(1, 4);
    for (int i = 0; i < len; i++) begin
      send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_random_streams();
    int target;
    for (int p = 0; p < RAND_PHASES; p++) begin
      jitter = (p != 2);
      set_direction((p % 2 == 0) ? DIR_DECODE : DIR_ENCODE);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if (pred_dir == DIR_ENCODE) begin
          send_encode_stream();
        end else if ($urandom_range(0, 9) == 0) begin
          send_noise();
        end else begin
          send_decode_stream();
        end
      end
    end
    jitter = 1'b1;
  endtask

  always @(posedge clk) begin
    if (ready_stall > 0) begin
      out_ready   <= 1'b0;
      ready_stall <= ready_stall - 1;
    end else begin
      out_ready <= 1'b1;
      if (jitter && $urandom_range(0, 99) < 15) ready_stall <= pick_gap();
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result %02h/%0b/%0b with nothing awaited",
                                  out_data.out_byte, out_data.out_last, out_data.out_error));
      end else begin
        want = awaited_results.pop_front();
        if (out_data.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte: expected %02h, got %02h",
                                    want.out_byte, out_data.out_byte));
        if (out_data.out_last !== want.out_last)
          report_mismatch($sformatf("out_last: expected %0b, got %0b",
                                    want.out_last, out_data.out_last));
        if (out_data.out_error !== want.out_error)
          report_mismatch($sformatf("out_error: expected %0b, got %0b",
                                    want.out_error, out_data.out_error));
      end
    end
  end

  // Ends the run when neither side has moved an item or a result for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_encode_directed();
    test_decode_directed();
    test_random_streams();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/b64c_pkg.sv
rtl/core/b64c_front.sv
rtl/core/b64c_fifo.sv
rtl/core/b64c_back.sv
rtl/core/base64_stream_codec.sv
dv/base64_stream_codec_tb.sv
